// ----- rtl/core/ptrd_pkg.sv -----
// package: types, opcodes and status codes of the packed text run decoder
`default_nettype none

package ptrd_pkg;

	// opcode bytes
	localparam logic [7:0] OP_BLANK_MAX    = 8'h77;
	localparam logic [7:0] OP_BLANK_BYTE   = 8'h78;
	localparam logic [7:0] OP_BLANK_WORD   = 8'h79;
	localparam logic [7:0] OP_FILL_BYTE    = 8'h7a;
	localparam logic [7:0] OP_FILL_WORD    = 8'h7b;
	localparam logic [7:0] OP_BLANK_BYTE_B = 8'h7c;
	localparam logic [7:0] OP_BLANK_WORD_B = 8'h7d;
	localparam logic [7:0] OP_FILL_BYTE_B  = 8'h7e;
	localparam logic [7:0] OP_FILL_WORD_B  = 8'h7f;
	localparam logic [7:0] OP_LIT_MIN      = 8'h80;
	localparam logic [7:0] OP_LIT_MAX      = 8'hf7;
	localparam logic [7:0] OP_LIT_BYTE     = 8'hf8;
	localparam logic [7:0] OP_LIT_WORD     = 8'hf9;
	localparam logic [7:0] OP_LIT_BYTE_B   = 8'hfc;
	localparam logic [7:0] OP_LIT_WORD_B   = 8'hfd;
	localparam logic [7:0] OP_END          = 8'hff;
	localparam logic [7:0] LIT_BIAS        = 8'h7f;
	localparam logic [7:0] EBCDIC_BLANK    = 8'h40;

	// configuration register indexes
	localparam logic [1:0] REG_SIZE_CEILING    = 2'd0;
	localparam logic [1:0] REG_BUFFER_CAPACITY = 2'd1;
	localparam logic [1:0] REG_MEASURE_MODE    = 2'd2;

	localparam logic [31:0] SIZE_CEILING_RESET    = 32'd16777216;
	localparam logic [31:0] BUFFER_CAPACITY_RESET = 32'hffff_ffff;

	localparam logic KIND_RUN     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		PH_OPCODE,
		PH_HIGH,
		PH_LOW,
		PH_RUNBYTE,
		PH_LITERAL
	} ptrd_phase_t;

	typedef enum logic [2:0] {
		ST_CLEAN,
		ST_INPUT_END,
		ST_BAD_OPCODE,
		ST_TRUNC_LITERAL,
		ST_TRUNC_OPERAND,
		ST_CEILING,
		ST_CAPACITY,
		ST_EMPTY
	} ptrd_status_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       end_of_member;
	} ptrd_in_t;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  run_byte;
		logic [16:0] run_length;
		logic [2:0]  end_status;
		logic [31:0] bytes_produced;
		logic [31:0] bytes_consumed;
		logic        final_flag;
	} ptrd_out_t;

	typedef struct packed {
		logic [31:0] size_ceiling;
		logic [31:0] buffer_capacity;
		logic        measure_mode;
	} ptrd_cfg_t;

	// one queued action: an optional run and an optional summary
	typedef struct packed {
		logic         has_run;
		logic [7:0]   run_byte;
		logic [16:0]  run_length;
		logic         has_sum;
		ptrd_status_t status;
		logic [31:0]  produced;
		logic [31:0]  consumed;
	} ptrd_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptrd_front.sv -----
// front end: opcode parser, member counters and limit checks
`default_nettype none

module ptrd_front
	import ptrd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire ptrd_in_t    item,
	input  wire ptrd_cfg_t   cfg,
	output logic             push,
	output ptrd_entry_t      entry
);

	ptrd_phase_t  phase_q, phase_after;
	logic [7:0]   opcode_q;
	logic [15:0]  count_q;
	logic [16:0]  lit_rem_q, lit_rem_next;
	logic [31:0]  produced_q, produced_after;
	logic [31:0]  consumed_q, consumed_after;
	logic         done_q;

	logic [7:0]   b;
	logic         eom;
	logic         op_short_blank, op_byte_cnt, op_word_cnt, op_lit_short, op_end;
	logic         held_run, held_lit;
	logic [15:0]  count_low;

	logic         fill_req, lit_req, lbyte_req;
	logic [7:0]   fill_byte;
	logic [16:0]  chk_len;
	logic [32:0]  chk_sum;
	logic         over_ceil, over_cap;
	logic         fill_ok, lit_ok, lbyte_ok, run_hit;
	logic         end_hit;
	ptrd_status_t end_code, end_final;
	logic         failed;

	assign b   = item.packed_byte;
	assign eom = item.end_of_member;

	assign op_short_blank = (b <= OP_BLANK_MAX);
	assign op_byte_cnt = (b == OP_BLANK_BYTE) || (b == OP_BLANK_BYTE_B) ||
		(b == OP_FILL_BYTE) || (b == OP_FILL_BYTE_B) ||
		(b == OP_LIT_BYTE) || (b == OP_LIT_BYTE_B);
	assign op_word_cnt = (b == OP_BLANK_WORD) || (b == OP_BLANK_WORD_B) ||
		(b == OP_FILL_WORD) || (b == OP_FILL_WORD_B) ||
		(b == OP_LIT_WORD) || (b == OP_LIT_WORD_B);
	assign op_lit_short = (b >= OP_LIT_MIN) && (b <= OP_LIT_MAX);
	assign op_end = (b == OP_END);

	assign held_run = (opcode_q == OP_FILL_BYTE) || (opcode_q == OP_FILL_BYTE_B) ||
		(opcode_q == OP_FILL_WORD) || (opcode_q == OP_FILL_WORD_B);
	assign held_lit = (opcode_q >= OP_LIT_BYTE);

	// the high byte was shifted in earlier, or is zero for a byte operand
	assign count_low = {count_q[15:8], b};

	// request decode and the shared limit check
	always_comb begin
		fill_req  = 1'b0;
		lit_req   = 1'b0;
		lbyte_req = 1'b0;
		fill_byte = EBCDIC_BLANK;
		chk_len   = '0;
		case (phase_q)
			PH_OPCODE: begin
				if (op_short_blank) begin
					fill_req = 1'b1;
					chk_len  = {9'd0, b} + 17'd1;
				end else if (op_lit_short) begin
					lit_req = 1'b1;
					chk_len = {9'd0, b - LIT_BIAS};
				end
			end
			PH_LOW: begin
				if (!held_run) begin
					fill_req = !held_lit;
					lit_req  = held_lit;
					chk_len  = {1'b0, count_low} + 17'd1;
				end
			end
			PH_RUNBYTE: begin
				fill_req  = 1'b1;
				fill_byte = b;
				chk_len   = {1'b0, count_q} + 17'd1;
			end
			PH_LITERAL: begin
				lbyte_req = 1'b1;
				fill_byte = b;
				chk_len   = 17'd1;
			end
			default: begin
				fill_req = 1'b0;
			end
		endcase
	end

	assign chk_sum   = {1'b0, produced_q} + {16'd0, chk_len};
	assign over_ceil = chk_sum > {1'b0, cfg.size_ceiling};
	assign over_cap  = chk_sum > {1'b0, cfg.buffer_capacity};
	assign fill_ok   = fill_req && !over_ceil && !over_cap;
	assign lit_ok    = lit_req && !over_ceil;
	assign lbyte_ok  = lbyte_req && !over_cap;
	assign run_hit   = fill_ok || lbyte_ok;

	assign lit_rem_next = (lit_rem_q != '0) ? lit_rem_q - 17'd1 : '0;

	// next parse phase
	always_comb begin
		phase_after = phase_q;
		case (phase_q)
			PH_OPCODE: begin
				if (op_byte_cnt) begin
					phase_after = PH_LOW;
				end else if (op_word_cnt) begin
					phase_after = PH_HIGH;
				end else if (lit_ok) begin
					phase_after = PH_LITERAL;
				end else begin
					phase_after = PH_OPCODE;
				end
			end
			PH_HIGH: begin
				phase_after = PH_LOW;
			end
			PH_LOW: begin
				if (held_run) begin
					phase_after = PH_RUNBYTE;
				end else if (lit_ok) begin
					phase_after = PH_LITERAL;
				end else begin
					phase_after = PH_OPCODE;
				end
			end
			PH_RUNBYTE: begin
				phase_after = PH_OPCODE;
			end
			PH_LITERAL: begin
				if (lbyte_ok && lit_rem_next == '0) begin
					phase_after = PH_OPCODE;
				end
			end
			default: begin
				phase_after = PH_OPCODE;
			end
		endcase
	end

	// end detection and the status it reports
	always_comb begin
		end_hit  = 1'b1;
		end_code = ST_CLEAN;
		if (fill_req && over_ceil) begin
			end_code = ST_CEILING;
		end else if (fill_req && over_cap) begin
			end_code = ST_CAPACITY;
		end else if (lit_req && over_ceil) begin
			end_code = ST_CEILING;
		end else if (lbyte_req && over_cap) begin
			end_code = ST_CAPACITY;
		end else if (phase_q == PH_OPCODE && op_end) begin
			end_code = ST_CLEAN;
		end else if (phase_q == PH_OPCODE && !op_short_blank && !op_byte_cnt &&
				!op_word_cnt && !op_lit_short) begin
			end_code = ST_BAD_OPCODE;
		end else if (eom) begin
			case (phase_after)
				PH_OPCODE:  end_code = ST_INPUT_END;
				PH_LITERAL: end_code = ST_TRUNC_LITERAL;
				default:    end_code = ST_TRUNC_OPERAND;
			endcase
		end else begin
			end_hit = 1'b0;
		end
	end

	assign produced_after = run_hit ? chk_sum[31:0] : produced_q;
	assign consumed_after = (consumed_q == '1) ? consumed_q : consumed_q + 32'd1;

	always_comb begin
		end_final = end_code;
		if (cfg.measure_mode && produced_after == '0 && end_code != ST_CEILING &&
				end_code != ST_CAPACITY) begin
			end_final = ST_EMPTY;
		end
	end

	assign failed = (end_final == ST_CEILING) || (end_final == ST_CAPACITY) ||
		(end_final == ST_EMPTY);

	assign push = accept && !done_q && (run_hit || end_hit);

	always_comb begin
		entry.has_run    = run_hit;
		entry.run_byte   = fill_byte;
		entry.run_length = chk_len;
		entry.has_sum    = end_hit;
		entry.status     = end_final;
		entry.produced   = failed ? '0 : produced_after;
		entry.consumed   = failed ? '0 : consumed_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_OPCODE;
			opcode_q   <= '0;
			count_q    <= '0;
			lit_rem_q  <= '0;
			produced_q <= '0;
			consumed_q <= '0;
			done_q     <= 1'b0;
		end else if (accept) begin
			if (eom) begin
				// last beat of the member always clears it
				phase_q    <= PH_OPCODE;
				opcode_q   <= '0;
				count_q    <= '0;
				lit_rem_q  <= '0;
				produced_q <= '0;
				consumed_q <= '0;
				done_q     <= 1'b0;
			end else if (!done_q) begin
				phase_q    <= phase_after;
				produced_q <= produced_after;
				consumed_q <= consumed_after;
				done_q     <= end_hit;
				case (phase_q)
					PH_OPCODE: begin
						opcode_q <= b;
						count_q  <= '0;
					end
					PH_HIGH: count_q <= {b, 8'd0};
					PH_LOW:  count_q <= count_low;
					default: count_q <= count_q;
				endcase
				if (lit_ok) begin
					lit_rem_q <= chk_len;
				end else if (lbyte_ok) begin
					lit_rem_q <= lit_rem_next;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ptrd_queue.sv -----
// action queue between parser and result sequencer
`default_nettype none

module ptrd_queue
	import ptrd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire ptrd_entry_t push_data,
	input  wire logic        pop,
	output ptrd_entry_t      head,
	output logic             not_empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ptrd_entry_t       entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/ptrd_back.sv -----
// back end: splits queued actions into result beats behind an output register
`default_nettype none

module ptrd_back
	import ptrd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ptrd_entry_t head,
	input  wire logic        head_valid,
	output logic             pop,
	output logic             result_valid,
	input  wire logic        result_ready,
	output ptrd_out_t        result
);

	logic      out_valid_q;
	ptrd_out_t out_q;
	logic      run_sent_q;
	logic      load;
	logic      send_run;
	logic      last;
	ptrd_out_t beat;

	assign load     = head_valid && (!out_valid_q || result_ready);
	assign send_run = head.has_run && !run_sent_q;
	assign last     = !send_run || !head.has_sum;
	assign pop      = load && last;

	always_comb begin
		if (send_run) begin
			beat.item_kind      = KIND_RUN;
			beat.run_byte       = head.run_byte;
			beat.run_length     = head.run_length;
			beat.end_status     = '0;
			beat.bytes_produced = '0;
			beat.bytes_consumed = '0;
			beat.final_flag     = !head.has_sum;
		end else begin
			beat.item_kind      = KIND_SUMMARY;
			beat.run_byte       = '0;
			beat.run_length     = '0;
			beat.end_status     = head.status;
			beat.bytes_produced = head.produced;
			beat.bytes_consumed = head.consumed;
			beat.final_flag     = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_sent_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				// run gone out, summary of the same entry still pending
				run_sent_q  <= !last;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/packed_text_run_decoder_unit.sv -----
// top level: configuration registers, parser, action queue and result sequencer
// path: an accepted beat is written into the queue and then loaded into the output register
// throughput: one input beat per cycle unless the queue is full; one result beat per cycle
// while result_ready is high; a run-and-summary beat gives two result beats (queue absorbs it)
// reset: configuration returns to its defaults, member state and queue are cleared
// no clearing pass; input is taken from the first cycle after reset
`default_nettype none

module packed_text_run_decoder_unit
	import ptrd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire ptrd_in_t    item,
	output logic             result_valid,
	input  wire logic        result_ready,
	output ptrd_out_t        result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	ptrd_cfg_t   cfg_q;
	logic        cfg_write;
	logic        accept;
	logic        push;
	ptrd_entry_t entry;
	ptrd_entry_t head;
	logic        head_valid;
	logic        full;
	logic        pop;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_ceiling    <= SIZE_CEILING_RESET;
			cfg_q.buffer_capacity <= BUFFER_CAPACITY_RESET;
			cfg_q.measure_mode    <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_SIZE_CEILING:    cfg_q.size_ceiling    <= pwdata;
				REG_BUFFER_CAPACITY: cfg_q.buffer_capacity <= pwdata;
				REG_MEASURE_MODE:    cfg_q.measure_mode    <= pwdata[0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SIZE_CEILING:    prdata = cfg_q.size_ceiling;
			REG_BUFFER_CAPACITY: prdata = cfg_q.buffer_capacity;
			REG_MEASURE_MODE:    prdata = {31'd0, cfg_q.measure_mode};
			default:             prdata = '0;
		endcase
	end

	assign item_ready = !full;
	assign accept     = item_valid && item_ready;

	ptrd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cfg    (cfg_q),
		.push   (push),
		.entry  (entry)
	);

	ptrd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid),
		.full      (full)
	);

	ptrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire
